[hw/rtl/mcpf_pkg.sv]
// types, constants and codes for the multi-channel pipe fifo
// used by every module of the block; no dependencies
package mcpf_pkg;

  localparam int unsigned CHANNELS      = 8;
  localparam int unsigned CHANNEL_DEPTH = 512;
  localparam int unsigned MAX_BURST     = 16;

  localparam int unsigned CH_W   = $clog2(CHANNELS);
  localparam int unsigned PTR_W  = $clog2(CHANNEL_DEPTH);
  localparam int unsigned FILL_W = 10;
  localparam int unsigned ADDR_W = CH_W + PTR_W;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DESC_W = 8;

  // operation codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;
  localparam logic [1:0] FUNC_CLOSE  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_FD  = 3'd1;
  localparam logic [2:0] ST_BLOCK   = 3'd2;
  localparam logic [2:0] ST_EOF     = 3'd3;
  localparam logic [2:0] ST_NO_FREE = 3'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [DESC_W-1:0] descriptor;
    logic [7:0]        write_data;
    logic [CNT_W-1:0]  read_count;
    logic [7:0]        task_id;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        channel_out;
    logic [7:0]        data_out;
    logic              data_valid;
    logic [CNT_W-1:0]  bytes_done;
    logic [FILL_W-1:0] fill_level;
    logic              wake_valid;
    logic [7:0]        wake_task;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic issue;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic burst;
    logic last_issue;
  } dp_stat_t;

endpackage

[hw/rtl/mcpf_ctrl.sv]
// controller state machine for the multi-channel pipe fifo
// depends on mcpf_pkg
module mcpf_ctrl import mcpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_BURST = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.burst ? S_BURST : S_IDLE;
      end
      S_BURST: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

[hw/rtl/mcpf_dpath.sv]
// datapath: channel table, byte memory, burst counter and result register
// depends on mcpf_pkg
module mcpf_dpath import mcpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       in_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      res_valid_o,
  output out_t      res_o
);

  // channel table
  logic [PTR_W-1:0]  rptr_q [CHANNELS];
  logic [PTR_W-1:0]  rptr_d [CHANNELS];
  logic [PTR_W-1:0]  wptr_q [CHANNELS];
  logic [PTR_W-1:0]  wptr_d [CHANNELS];
  logic [FILL_W-1:0] fill_q [CHANNELS];
  logic [FILL_W-1:0] fill_d [CHANNELS];
  logic [CHANNELS-1:0] ropen_q, ropen_d, wopen_q, wopen_d;
  logic [CHANNELS-1:0] rwait_q, rwait_d, wwait_q, wwait_d;
  logic [7:0] rtask_q [CHANNELS];
  logic [7:0] rtask_d [CHANNELS];
  logic [7:0] wtask_q [CHANNELS];
  logic [7:0] wtask_d [CHANNELS];

  // byte memory
  logic [7:0] mem [CHANNELS*CHANNEL_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        rdata_q;

  in_t op_q;

  // burst state
  logic [CH_W-1:0]   bch_q, bch_d;
  logic [PTR_W-1:0]  bptr_q, bptr_d;
  logic [CNT_W-1:0]  bi_q, bi_d, bn_q, bn_d;
  logic [FILL_W-1:0] bfill_q, bfill_d;
  logic              bwv_q, bwv_d;
  logic [7:0]        bwt_q, bwt_d;

  out_t res_q, res_d;
  logic valid_q, valid_d, burst;

  // decoded channel numbers
  logic [DESC_W-2:0] rch7, wch7;
  logic [DESC_W-1:0] wsub;
  logic              rbad, wbad, found;
  logic [CH_W-1:0]   rch, wch;
  logic [CNT_W-1:0]  n;
  logic [FILL_W-1:0] fsel;

  assign rch7 = op_q.descriptor[DESC_W-1:1];
  assign wsub = op_q.descriptor - DESC_W'(1);
  assign wch7 = wsub[DESC_W-1:1];
  assign rbad = ({1'b0, rch7} >= DESC_W'(CHANNELS));
  assign wbad = (op_q.descriptor == '0) || ({1'b0, wch7} >= DESC_W'(CHANNELS));
  assign rch  = rch7[CH_W-1:0];
  assign wch  = wch7[CH_W-1:0];
  assign fsel = fill_q[rch];

  // burst length: request clamped to max burst and to fill
  always_comb begin
    n = (op_q.read_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : op_q.read_count;
    if (fsel < FILL_W'(n)) n = fsel[CNT_W-1:0];
  end

  // operation execution and burst stepping
  always_comb begin
    rptr_d = rptr_q; wptr_d = wptr_q; fill_d = fill_q;
    ropen_d = ropen_q; wopen_d = wopen_q;
    rwait_d = rwait_q; wwait_d = wwait_q;
    rtask_d = rtask_q; wtask_d = wtask_q;
    bch_d = bch_q; bptr_d = bptr_q; bi_d = bi_q; bn_d = bn_q;
    bfill_d = bfill_q; bwv_d = bwv_q; bwt_d = bwt_q;
    res_d = '0; res_d.last = 1'b1;
    valid_d = 1'b0; burst = 1'b0; found = 1'b0;
    mem_we = 1'b0; mem_waddr = {wch, wptr_q[wch]};
    if (cmd_i.exec) begin
      valid_d = 1'b1;
      unique case (op_q.func)
        FUNC_CREATE: begin
          res_d.status = ST_NO_FREE;
          for (int i = 0; i < CHANNELS; i++) begin
            if (!found && !ropen_q[i]) begin
              found = 1'b1;
              rptr_d[i] = '0; wptr_d[i] = '0; fill_d[i] = '0;
              ropen_d[i] = 1'b1; wopen_d[i] = 1'b1;
              rwait_d[i] = 1'b0; wwait_d[i] = 1'b0;
              res_d.status = ST_OK;
              res_d.channel_out = 3'(i);
            end
          end
        end
        FUNC_READ: begin
          if (rbad) res_d.status = ST_BAD_FD;
          else if (fsel == '0) begin
            if (!wopen_q[rch]) res_d.status = ST_EOF;
            else begin
              res_d.status = ST_BLOCK;
              rwait_d[rch] = 1'b1;
              rtask_d[rch] = op_q.task_id;
            end
          end else begin
            if (wwait_q[rch]) begin
              wwait_d[rch] = 1'b0;
              res_d.wake_valid = 1'b1;
              res_d.wake_task  = wtask_q[rch];
            end
            res_d.fill_level = fsel;
            if (n != '0) begin
              // hand over to the burst; results come from the issue path
              valid_d = 1'b0;
              burst   = 1'b1;
              bch_d = rch; bptr_d = rptr_q[rch]; bi_d = '0; bn_d = n;
              bfill_d = fsel - FILL_W'(n);
              bwv_d = res_d.wake_valid; bwt_d = res_d.wake_task;
              rptr_d[rch] = rptr_q[rch] + PTR_W'(n);
              fill_d[rch] = fsel - FILL_W'(n);
            end
          end
        end
        FUNC_WRITE: begin
          if (wbad) res_d.status = ST_BAD_FD;
          else if (fill_q[wch] >= FILL_W'(CHANNEL_DEPTH)) begin
            res_d.status = ST_BLOCK;
            res_d.fill_level = fill_q[wch];
            wwait_d[wch] = 1'b1;
            wtask_d[wch] = op_q.task_id;
          end else begin
            mem_we = 1'b1;
            wptr_d[wch] = wptr_q[wch] + PTR_W'(1);
            fill_d[wch] = fill_q[wch] + FILL_W'(1);
            res_d.bytes_done = CNT_W'(1);
            res_d.fill_level = fill_q[wch] + FILL_W'(1);
            if (rwait_q[wch]) begin
              rwait_d[wch] = 1'b0;
              res_d.wake_valid = 1'b1;
              res_d.wake_task  = rtask_q[wch];
            end
          end
        end
        FUNC_CLOSE: begin
          if (rbad) res_d.status = ST_BAD_FD;
          else begin
            res_d.fill_level = fsel;
            if (!op_q.descriptor[0]) begin
              ropen_d[rch] = 1'b0;
              if (wwait_q[rch]) begin
                wwait_d[rch] = 1'b0;
                res_d.wake_valid = 1'b1;
                res_d.wake_task  = wtask_q[rch];
              end
            end else begin
              wopen_d[rch] = 1'b0;
              if (rwait_q[rch]) begin
                rwait_d[rch] = 1'b0;
                res_d.wake_valid = 1'b1;
                res_d.wake_task  = rtask_q[rch];
              end
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.issue) begin
      // one byte per cycle; data joins from the memory register
      valid_d = 1'b1;
      res_d.data_valid = 1'b1;
      res_d.bytes_done = bi_q + CNT_W'(1);
      res_d.fill_level = bfill_q;
      res_d.last       = stat_o.last_issue;
      res_d.wake_valid = stat_o.last_issue & bwv_q;
      res_d.wake_task  = stat_o.last_issue ? bwt_q : 8'd0;
      bptr_d = bptr_q + PTR_W'(1);
      bi_d   = bi_q + CNT_W'(1);
    end
  end

  assign stat_o.burst      = burst;
  assign stat_o.last_issue = (bi_q + CNT_W'(1) == bn_q);

  // byte memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= op_q.write_data;
    rdata_q <= mem[{bch_q, bptr_q}];
  end

  // input item, burst and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) op_q <= in_i;
    bch_q <= bch_d; bptr_q <= bptr_d; bi_q <= bi_d; bn_q <= bn_d;
    bfill_q <= bfill_d; bwv_q <= bwv_d; bwt_q <= bwt_d;
    res_q <= res_d;
  end

  // channel table and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rptr_q[i] <= '0; wptr_q[i] <= '0; fill_q[i] <= '0;
        rtask_q[i] <= '0; wtask_q[i] <= '0;
      end
      ropen_q <= '0; wopen_q <= '0; rwait_q <= '0; wwait_q <= '0;
      valid_q <= 1'b0;
    end else begin
      rptr_q <= rptr_d; wptr_q <= wptr_d; fill_q <= fill_d;
      rtask_q <= rtask_d; wtask_q <= wtask_d;
      ropen_q <= ropen_d; wopen_q <= wopen_d;
      rwait_q <= rwait_d; wwait_q <= wwait_d;
      valid_q <= valid_d;
    end
  end

  // read bytes take the memory output
  always_comb begin
    res_o = res_q;
    if (res_q.data_valid) res_o.data_out = rdata_q;
  end
  assign res_valid_o = valid_q;

endmodule

[hw/rtl/multi_channel_pipe_fifo_top.sv]
// top level of the multi-channel pipe fifo: controller plus datapath
// depends on mcpf_pkg, mcpf_ctrl, mcpf_dpath
// each item is loaded in the idle state and executed in the exec state; a read
// burst then stays in the burst state until its last byte is issued,
// one byte per cycle from the single read port of the byte memory
// reset clears the channel table; byte memory contents are not cleared
module multi_channel_pipe_fifo_top import mcpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic res_valid_o,
  output out_t res_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mcpf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  mcpf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after start");
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && res_o.data_valid)
    else $error("burst result missing");
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result right after final result");
`endif

endmodule

[verif/testbench.sv]
// self-checking testbench for the multi-channel pipe fifo
// depends on mcpf_pkg and multi_channel_pipe_fifo_top
`timescale 1ns / 1ps

module testbench;
  import mcpf_pkg::*;

  // scoreboard: channel table shadow plus queue of predicted results
  class pipe_scoreboard;
    logic [PTR_W-1:0]  rd_ptr [CHANNELS];
    logic [PTR_W-1:0]  wr_ptr [CHANNELS];
    logic [FILL_W-1:0] fill [CHANNELS];
    bit                rd_open [CHANNELS];
    bit                wr_open [CHANNELS];
    bit                rd_wait [CHANNELS];
    logic [7:0]        rd_task [CHANNELS];
    bit                wr_wait [CHANNELS];
    logic [7:0]        wr_task [CHANNELS];
    logic [7:0]        bytes [CHANNELS*CHANNEL_DEPTH];
    out_t              pending[$];
    int                errors;
    int                n_results;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        rd_ptr[c] = '0; wr_ptr[c] = '0; fill[c] = '0;
        rd_open[c] = 0; wr_open[c] = 0; rd_wait[c] = 0; wr_wait[c] = 0;
        rd_task[c] = '0; wr_task[c] = '0;
      end
      errors = 0;
      n_results = 0;
    endfunction

    function void push(logic [2:0] st, logic [2:0] chn, logic [7:0] d, bit dv,
                       logic [CNT_W-1:0] done, logic [FILL_W-1:0] fl, bit wv,
                       logic [7:0] wt, bit lst);
      out_t r;
      r.status = st; r.channel_out = chn; r.data_out = d; r.data_valid = dv;
      r.bytes_done = done; r.fill_level = fl; r.wake_valid = wv;
      r.wake_task = wt; r.last = lst;
      pending.push_back(r);
    endfunction

    // predict the results of one accepted item
    function void note_item(in_t it);
      int ch;
      int n;
      bit wv;
      logic [7:0] wt;
      bit found;
      wv = 0; wt = '0; found = 0;
      case (it.func)
        FUNC_CREATE: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (!found && !rd_open[c]) begin
              found = 1;
              rd_ptr[c] = '0; wr_ptr[c] = '0; fill[c] = '0;
              rd_open[c] = 1; wr_open[c] = 1; rd_wait[c] = 0; wr_wait[c] = 0;
              push(ST_OK, c[2:0], 0, 0, 0, 0, 0, 0, 1);
            end
          end
          if (!found) push(ST_NO_FREE, 0, 0, 0, 0, 0, 0, 0, 1);
        end
        FUNC_READ: begin
          ch = int'(it.descriptor >> 1);
          if (ch >= CHANNELS) push(ST_BAD_FD, 0, 0, 0, 0, 0, 0, 0, 1);
          else if (fill[ch] == 0) begin
            if (!wr_open[ch]) push(ST_EOF, 0, 0, 0, 0, 0, 0, 0, 1);
            else begin
              rd_wait[ch] = 1; rd_task[ch] = it.task_id;
              push(ST_BLOCK, 0, 0, 0, 0, 0, 0, 0, 1);
            end
          end else begin
            n = int'(it.read_count);
            if (n > MAX_BURST) n = MAX_BURST;
            if (n > fill[ch]) n = int'(fill[ch]);
            if (wr_wait[ch]) begin
              wv = 1; wt = wr_task[ch]; wr_wait[ch] = 0;
            end
            if (n == 0) push(ST_OK, 0, 0, 0, 0, fill[ch], wv, wt, 1);
            else begin
              for (int i = 0; i < n; i++) begin
                push(ST_OK, 0, bytes[ch*CHANNEL_DEPTH + ((rd_ptr[ch] + i) % CHANNEL_DEPTH)],
                     1, CNT_W'(i + 1), FILL_W'(fill[ch] - n), (i == n-1) ? wv : 0,
                     (i == n-1) ? wt : 8'd0, i == n-1);
              end
              rd_ptr[ch] = PTR_W'((rd_ptr[ch] + n) % CHANNEL_DEPTH);
              fill[ch] = FILL_W'(fill[ch] - n);
            end
          end
        end
        FUNC_WRITE: begin
          if (it.descriptor == 0 || ((it.descriptor - 1) >> 1) >= CHANNELS)
            push(ST_BAD_FD, 0, 0, 0, 0, 0, 0, 0, 1);
          else begin
            ch = int'((it.descriptor - 1) >> 1);
            if (fill[ch] >= CHANNEL_DEPTH) begin
              wr_wait[ch] = 1; wr_task[ch] = it.task_id;
              push(ST_BLOCK, 0, 0, 0, 0, fill[ch], 0, 0, 1);
            end else begin
              bytes[ch*CHANNEL_DEPTH + wr_ptr[ch]] = it.write_data;
              wr_ptr[ch] = wr_ptr[ch] + PTR_W'(1);
              fill[ch] = fill[ch] + FILL_W'(1);
              if (rd_wait[ch]) begin
                wv = 1; wt = rd_task[ch]; rd_wait[ch] = 0;
              end
              push(ST_OK, 0, 0, 0, 1, fill[ch], wv, wt, 1);
            end
          end
        end
        default: begin
          ch = int'(it.descriptor >> 1);
          if (ch >= CHANNELS) push(ST_BAD_FD, 0, 0, 0, 0, 0, 0, 0, 1);
          else begin
            if (!it.descriptor[0]) begin
              rd_open[ch] = 0;
              if (wr_wait[ch]) begin
                wv = 1; wt = wr_task[ch]; wr_wait[ch] = 0;
              end
            end else begin
              wr_open[ch] = 0;
              if (rd_wait[ch]) begin
                wv = 1; wt = rd_task[ch]; rd_wait[ch] = 0;
              end
            end
            push(ST_OK, 0, 0, 0, 0, fill[ch], wv, wt, 1);
          end
        end
      endcase
    endfunction

    // compare one result against the oldest prediction
    function void check_result(out_t got);
      out_t e;
      n_results++;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.channel_out !== e.channel_out) begin
        $error("channel_out exp %0d got %0d", e.channel_out, got.channel_out); errors++;
      end
      if (got.data_out !== e.data_out) begin
        $error("data_out exp %0h got %0h", e.data_out, got.data_out); errors++;
      end
      if (got.data_valid !== e.data_valid) begin
        $error("data_valid exp %0d got %0d", e.data_valid, got.data_valid); errors++;
      end
      if (got.bytes_done !== e.bytes_done) begin
        $error("bytes_done exp %0d got %0d", e.bytes_done, got.bytes_done); errors++;
      end
      if (got.fill_level !== e.fill_level) begin
        $error("fill_level exp %0d got %0d", e.fill_level, got.fill_level); errors++;
      end
      if (got.wake_valid !== e.wake_valid) begin
        $error("wake_valid exp %0d got %0d", e.wake_valid, got.wake_valid); errors++;
      end
      if (got.wake_task !== e.wake_task) begin
        $error("wake_task exp %0h got %0h", e.wake_task, got.wake_task); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  in_t  in_i = '0;
  logic res_valid_o;
  out_t res_o;

  pipe_scoreboard sb;
  int n_items = 0;

  multi_channel_pipe_fifo_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // hold one item on the inputs until it is accepted
  task automatic send_item(logic [1:0] f, logic [7:0] d, logic [7:0] wd,
                           logic [4:0] cnt, logic [7:0] tid);
    int gap;
    bit taken;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    in_i.func = f; in_i.descriptor = d; in_i.write_data = wd;
    in_i.read_count = cnt; in_i.task_id = tid;
    start = 1;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1;
        sb.note_item(in_i);
        n_items++;
      end
    end
    @(negedge clk_i);
    start = 0;
    in_i = '0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // pick a descriptor, mostly on valid channel numbers
  function automatic logic [7:0] pick_fd(bit wr_end);
    int c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    c = $urandom_range(0, CHANNELS - 1);
    return wr_end ? 8'(c*2 + 1) : 8'(c*2);
  endfunction

  // main stimulus
  initial begin
    int c;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: read on empty/closed, bad fds, create all, full exercise
    send_item(FUNC_READ, 8'd0, 8'h00, 5'd0, 8'h00);
    send_item(FUNC_READ, 8'd255, 8'hff, 5'd31, 8'hff);
    send_item(FUNC_WRITE, 8'd0, 8'hff, 5'd0, 8'h01);
    send_item(FUNC_WRITE, 8'd17, 8'h55, 5'd0, 8'h02);
    send_item(FUNC_CLOSE, 8'd16, 8'h00, 5'd0, 8'h03);
    for (int i = 0; i < CHANNELS + 1; i++) send_item(FUNC_CREATE, 0, 0, 0, 8'h00);
    send_item(FUNC_READ, 8'd2, 8'h00, 5'd4, 8'hab);
    send_item(FUNC_WRITE, 8'd3, 8'hff, 5'd0, 8'h00);
    send_item(FUNC_WRITE, 8'd3, 8'h00, 5'd0, 8'h00);
    send_item(FUNC_READ, 8'd2, 8'h00, 5'd0, 8'h00);
    send_item(FUNC_READ, 8'd2, 8'h00, 5'd31, 8'h00);
    send_item(FUNC_READ, 8'd4, 8'h00, 5'd1, 8'hcd);
    send_item(FUNC_CLOSE, 8'd5, 8'h00, 5'd0, 8'h00);
    send_item(FUNC_READ, 8'd4, 8'h00, 5'd1, 8'h00);
    send_item(FUNC_CLOSE, 8'd4, 8'h00, 5'd0, 8'h00);
    send_item(FUNC_CREATE, 0, 0, 0, 0);

    // fill channel 0 to the brim, block a writer, release via read
    for (int i = 0; i < CHANNEL_DEPTH; i++)
      send_item(FUNC_WRITE, 8'd1, 8'($urandom), 5'd0, 8'h00);
    send_item(FUNC_WRITE, 8'd1, 8'h77, 5'd0, 8'h99);
    send_item(FUNC_READ, 8'd0, 8'h00, 5'd16, 8'h00);
    send_item(FUNC_WRITE, 8'd1, 8'h77, 5'd0, 8'h5a);
    send_item(FUNC_CLOSE, 8'd0, 8'h00, 5'd0, 8'h00);
    drain();

    // random items, mostly read and write traffic
    for (int i = 0; i < 100; i++) begin
      c = $urandom_range(0, 99);
      if (c < 6) send_item(FUNC_CREATE, 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
      else if (c < 40) send_item(FUNC_READ, pick_fd(0), 8'($urandom),
                                 5'($urandom_range(0, 31)), 8'($urandom));
      else if (c < 92) send_item(FUNC_WRITE, pick_fd(1), 8'($urandom),
                                 5'($urandom), 8'($urandom));
      else send_item(FUNC_CLOSE, pick_fd(1'($urandom_range(0, 1))), 8'($urandom),
                     5'($urandom), 8'($urandom));
      if (i == 50) drain();
    end
    drain();

    $display("run covered %0d items and %0d results across all operations",
             n_items, sb.n_results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
